// ===== src/liap_pkg.sv =====
package liap_pkg;

   localparam int MaxSamples   = 4096;
   localparam int SampleBits   = 16;
   localparam int AddrBits     = $clog2(MaxSamples);
   localparam int CountBits    = AddrBits + 1;
   localparam int SumBits      = SampleBits + CountBits;
   localparam int AccBits      = 48;
   localparam int CordicSteps  = 30;
   localparam int StepBits     = 5;
   localparam int CordicGainQ30 = 652032874;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_STEP  = 2'd1,
      ST_TOO_FEW   = 2'd2,
      ST_TOO_MANY  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_PHASE_STEP  = 2'd0,
      CSR_START_PHASE = 2'd1,
      CSR_REMOVE_DC   = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_LOAD,
      S_DIV_MEAN,
      S_MIX_READ,
      S_MIX_CORDIC,
      S_MIX_ACC,
      S_DIV_I,
      S_DIV_Q,
      S_SQRT,
      S_ATAN,
      S_DONE
   } state_type;

   function automatic logic [31:0] turn_atan(input logic [StepBits-1:0] k);
      logic [31:0] r;
      begin
         unique case (k)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517C;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A2F;
            5'd19: r = 32'h00000517;
            5'd20: r = 32'h0000028B;
            5'd21: r = 32'h00000145;
            5'd22: r = 32'h000000A2;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000028;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000002;
            5'd29: r = 32'h00000001;
            default: r = 32'h0;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== src/liap_ram.sv =====
module liap_ram #(
   parameter int Width = 16,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/liap_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle, rounding down.
module liap_div
   import liap_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [AccBits-1:0] numer,
   input  logic [AccBits-1:0] denom,
   output logic               done,
   output logic [AccBits-1:0] quot
);
   logic [AccBits-1:0] rem_ff, rem_in, q_ff, q_in, n_ff, n_in, d_ff, d_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic [AccBits:0]   trial;

   always_comb begin
      rem_in = rem_ff; q_in = q_ff; n_in = n_ff; d_in = d_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, n_ff[AccBits-1]};
      if (go) begin
         // numerator already carries + d/2
         n_in = numer; d_in = denom; rem_in = '0; q_in = '0;
         cnt_in = 7'(AccBits); busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = {n_ff[AccBits-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            rem_in = AccBits'(trial - {1'b0, d_ff});
            q_in = {q_ff[AccBits-2:0], 1'b1};
         end else begin
            rem_in = trial[AccBits-1:0];
            q_in = {q_ff[AccBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; q_ff <= q_in; n_ff <= n_in; d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

// ===== src/liap_cordic.sv =====
// Shared CORDIC: rotation for cos/sin, vectoring for atan2. One step a cycle.
module liap_cordic
   import liap_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic               vectoring,
   input  logic signed [39:0] x0,
   input  logic signed [39:0] y0,
   input  logic signed [32:0] z0,
   output logic               done,
   output logic signed [39:0] x_out,
   output logic signed [39:0] y_out,
   output logic signed [32:0] z_out
);
   logic signed [39:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [32:0] z_ff, z_in, at;
   logic [StepBits-1:0] k_ff, k_in;
   logic busy_ff, busy_in, done_ff, done_in, vec_ff, vec_in, dir;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; k_in = k_ff;
      busy_in = busy_ff; done_in = 1'b0; vec_in = vec_ff;
      dx = y_ff >>> k_ff;
      dy = x_ff >>> k_ff;
      at = 33'(turn_atan(k_ff));
      // dir high: rotate x -= dx style
      dir = vec_ff ? (y_ff <= 0) : (z_ff >= 0);
      if (go) begin
         x_in = x0; y_in = y0; z_in = z0; k_in = '0;
         busy_in = 1'b1; vec_in = vectoring;
      end else if (busy_ff) begin
         if (dir) begin
            x_in = x_ff - dx; y_in = y_ff + dy; z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx; y_in = y_ff - dy; z_in = z_ff + at;
         end
         k_in = k_ff + 1'b1;
         if (k_ff == StepBits'(CordicSteps - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; k_ff <= k_in; vec_ff <= vec_in;
   end

   assign done = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
endmodule

// ===== src/lock_in_amplitude_phase_top.sv =====
// Lock-in amplitude and phase detector over a block of samples.
// Input: pulse start with req_sample/req_last while busy is low; one sample
// is taken each cycle during loading. Up to 4096 samples are kept in a RAM;
// later ones are dropped and flagged.
// The sample with req_last high closes the block: busy rises and the finishing
// pass runs: mean division, then per sample one RAM read, a 30-step CORDIC
// and a multiply-accumulate, two divisions, a bit-pair square root and a
// 30-step CORDIC vectoring for the angle, skipped when both parts are zero.
// The sample RAM port and the shared CORDIC set the pace of this pass.
// Error blocks skip the pass and go straight to the result.
// The result appears on the rsp_ ports for one cycle with rsp_valid; the
// receiver cannot stall. busy falls in the same cycle; the next block may start.
// Configuration via csr_we/csr_index/csr_data, only while busy is low; the block itself does not enforce this.
// Reset clears the block counters and configuration registers; no RAM clearing.
module lock_in_amplitude_phase_top
   import liap_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_sample,
   input  logic               req_last,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_mean_level,
   output logic signed [16:0] rsp_in_phase,
   output logic signed [16:0] rsp_quadrature,
   output logic [16:0]        rsp_magnitude,
   output logic signed [15:0] rsp_phase_angle
);
   state_type state_ff, state_in;
   logic [31:0] step_ff, start_ph_ff;
   logic        dc_ff;
   logic [CountBits-1:0] cnt_ff, cnt_in, k_ff, k_in;
   logic        ovf_ff, ovf_in;
   logic signed [SumBits-1:0] sum_ff, sum_in;
   logic signed [AccBits-1:0] cacc_ff, cacc_in, sacc_ff, sacc_in;
   logic [31:0] ph_ff, ph_in;
   logic signed [16:0] mean_ff, mean_in;
   logic signed [16:0] ip_ff, ip_in, qd_ff, qd_in;
   logic [16:0] mag_ff, mag_in;
   logic [15:0] ang_ff, ang_in;
   logic [1:0]  status_ff, status_in;
   logic        valid_ff, valid_in;
   logic signed [17:0] v_ff, v_in;
   logic        flip_ff, flip_in;
   logic signed [17:0] c_ff, c_in, s_ff, s_in;
   logic        mix_phase_ff, mix_phase_in;
   // square root registers
   logic [33:0] sq_n_ff, sq_n_in, sq_r_ff, sq_r_in, sq_b_ff, sq_b_in, sq_v_ff, sq_v_in;

   logic take;
   logic ram_we;
   logic [15:0] ram_q;
   logic [AddrBits-1:0] ram_ra;

   logic div_go, div_done;
   logic [AccBits-1:0] div_n, div_d, div_q;
   logic cor_go, cor_vec, cor_done;
   logic signed [39:0] cor_x0, cor_y0, cor_x, cor_y;
   logic signed [32:0] cor_z0, cor_z;

   assign take = start && !busy;
   assign ram_we = take && (cnt_ff < CountBits'(MaxSamples));

   liap_ram #(.Width(16), .Depth(MaxSamples)) u_store (
      .clock(clock), .wr_en(ram_we), .wr_addr(cnt_ff[AddrBits-1:0]),
      .wr_data(req_sample), .rd_addr(ram_ra), .rd_data(ram_q)
   );

   liap_div u_div (
      .clock(clock), .reset(reset), .go(div_go), .numer(div_n), .denom(div_d),
      .done(div_done), .quot(div_q)
   );

   liap_cordic u_cordic (
      .clock(clock), .reset(reset), .go(cor_go), .vectoring(cor_vec),
      .x0(cor_x0), .y0(cor_y0), .z0(cor_z0), .done(cor_done),
      .x_out(cor_x), .y_out(cor_y), .z_out(cor_z)
   );

   assign ram_ra = k_ff[AddrBits-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0; start_ph_ff <= '0; dc_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PHASE_STEP:  step_ff <= csr_data;
            CSR_START_PHASE: start_ph_ff <= csr_data;
            CSR_REMOVE_DC:   dc_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // helpers
   logic [AccBits-1:0] abs_acc, n_scaled;
   logic signed [AccBits-1:0] cur_acc;
   logic signed [AccBits:0] q_signed;
   logic signed [19:0] mixprod_v;
   logic signed [35:0] prod_c, prod_s;
   logic signed [40:0] rnd_x, rnd_y;
   logic [33:0] sq_t;
   logic [31:0] z_u, ang_r;
   logic signed [16:0] sat_v;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; k_in = k_ff; ovf_in = ovf_ff;
      sum_in = sum_ff; cacc_in = cacc_ff; sacc_in = sacc_ff; ph_in = ph_ff;
      mean_in = mean_ff; ip_in = ip_ff; qd_in = qd_ff; mag_in = mag_ff;
      ang_in = ang_ff; status_in = status_ff; valid_in = 1'b0; v_in = v_ff;
      flip_in = flip_ff; c_in = c_ff; s_in = s_ff; mix_phase_in = mix_phase_ff;
      sq_n_in = sq_n_ff; sq_r_in = sq_r_ff; sq_b_in = sq_b_ff; sq_v_in = sq_v_ff;
      div_go = 1'b0; div_n = '0; div_d = '0;
      cor_go = 1'b0; cor_vec = 1'b0; cor_x0 = '0; cor_y0 = '0; cor_z0 = '0;
      cur_acc = mix_phase_ff ? sacc_ff : cacc_ff;
      abs_acc = cur_acc[AccBits-1] ? AccBits'(-cur_acc) : AccBits'(cur_acc);
      n_scaled = AccBits'(cnt_ff) << 14;
      q_signed = cur_acc[AccBits-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
      sat_v = (q_signed > 65535) ? 17'sd65535 :
              (q_signed < -65536) ? -17'sd65536 : 17'(q_signed);
      mixprod_v = 20'($signed(ram_q)) - (dc_ff ? 20'(mean_ff) : 20'sd0);
      prod_c = v_ff * c_ff;
      prod_s = v_ff * s_ff;
      rnd_x = (41'(cor_x) + 41'sd16384) >>> 15;
      rnd_y = (41'(cor_y) + 41'sd16384) >>> 15;
      sq_t = sq_r_ff + sq_b_ff;
      z_u = 32'(cor_z);
      ang_r = z_u + 32'h8000;
      unique case (state_ff)
         S_LOAD: begin
            if (take) begin
               if (cnt_ff < CountBits'(MaxSamples)) begin
                  cnt_in = cnt_ff + 1'b1;
                  sum_in = sum_ff + SumBits'(req_sample);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  mean_in = '0; ip_in = '0; qd_in = '0; mag_in = '0; ang_in = '0;
                  if (cnt_in < CountBits'(2)) begin
                     status_in = ST_TOO_FEW; state_in = S_DONE;
                  end else if (step_ff == 32'd0 || step_ff[31]) begin
                     status_in = ST_BAD_STEP; state_in = S_DONE;
                  end else if (ovf_in) begin
                     status_in = ST_TOO_MANY; state_in = S_DONE;
                  end else begin
                     status_in = ST_OK; state_in = S_DIV_MEAN;
                     div_go = 1'b1;
                     div_n = (sum_in[SumBits-1] ? AccBits'(-sum_in) : AccBits'(sum_in))
                             + AccBits'(cnt_in >> 1);
                     div_d = AccBits'(cnt_in);
                  end
               end
            end
         end
         S_DIV_MEAN: begin
            if (div_done) begin
               mean_in = sum_ff[SumBits-1] ? -17'(div_q) : 17'(div_q);
               k_in = '0; ph_in = start_ph_ff; cacc_in = '0; sacc_in = '0;
               state_in = S_MIX_READ;
            end
         end
         S_MIX_READ: begin
            // RAM data valid next cycle; start CORDIC now
            cor_go = 1'b1;
            flip_in = (ph_ff[31:30] == 2'b01) || (ph_ff[31:30] == 2'b10);
            cor_x0 = 40'(CordicGainQ30);
            cor_z0 = flip_in ? 33'($signed(ph_ff - 32'h80000000)) : 33'($signed(ph_ff));
            state_in = S_MIX_CORDIC;
         end
         S_MIX_CORDIC: begin
            if (k_ff == cnt_ff) begin
               state_in = S_DIV_I; mix_phase_in = 1'b0;
               div_go = 1'b1;
               div_n = (cacc_ff[AccBits-1] ? AccBits'(-cacc_ff) : AccBits'(cacc_ff))
                       + (n_scaled >> 1);
               div_d = n_scaled;
            end else begin
               v_in = mixprod_v[17:0];
               if (cor_done) begin
                  c_in = flip_ff ? -18'(rnd_x) : 18'(rnd_x);
                  s_in = flip_ff ? -18'(rnd_y) : 18'(rnd_y);
                  state_in = S_MIX_ACC;
               end
            end
         end
         S_MIX_ACC: begin
            cacc_in = cacc_ff + AccBits'(prod_c);
            sacc_in = sacc_ff - AccBits'(prod_s);
            ph_in = ph_ff + step_ff;
            k_in = k_ff + 1'b1;
            state_in = (k_in == cnt_ff) ? S_MIX_CORDIC : S_MIX_READ;
         end
         S_DIV_I: begin
            if (div_done) begin
               if (!mix_phase_ff) begin
                  ip_in = sat_v; mix_phase_in = 1'b1;
                  div_go = 1'b1;
                  div_n = (sacc_ff[AccBits-1] ? AccBits'(-sacc_ff) : AccBits'(sacc_ff))
                          + (n_scaled >> 1);
                  div_d = n_scaled;
               end else begin
                  qd_in = sat_v;
                  sq_v_in = 34'(34'(ip_ff) * 34'(ip_ff)) + 34'(34'(sat_v) * 34'(sat_v));
                  sq_n_in = sq_v_in; sq_r_in = '0; sq_b_in = 34'h1 << 32;
                  state_in = S_SQRT;
               end
            end
         end
         S_SQRT: begin
            if (sq_b_ff != 0) begin
               if (sq_n_ff >= sq_t) begin
                  sq_n_in = sq_n_ff - sq_t; sq_r_in = (sq_r_ff >> 1) + sq_b_ff;
               end else begin
                  sq_r_in = sq_r_ff >> 1;
               end
               sq_b_in = sq_b_ff >> 2;
            end else begin
               // sq_n_ff now holds v - r*r
               mag_in = (sq_n_ff > sq_r_ff) ? 17'(sq_r_ff + 1) : 17'(sq_r_ff);
               if (ip_ff == 0 && qd_ff == 0) begin
                  ang_in = '0; state_in = S_DONE;
               end else begin
                  cor_go = 1'b1; cor_vec = 1'b1;
                  cor_x0 = ip_ff[16] ? -(40'(ip_ff) <<< 20) : (40'(ip_ff) <<< 20);
                  cor_y0 = ip_ff[16] ? -(40'(qd_ff) <<< 20) : (40'(qd_ff) <<< 20);
                  cor_z0 = ip_ff[16] ? 33'h080000000 : 33'd0;
                  state_in = S_ATAN;
               end
            end
         end
         S_ATAN: begin
            if (cor_done) begin
               ang_in = ang_r[31:16];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            valid_in = 1'b1;
            cnt_in = '0; ovf_in = 1'b0; sum_in = '0; cacc_in = '0; sacc_in = '0;
            state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; cnt_ff <= '0; ovf_ff <= 1'b0; sum_ff <= '0;
         cacc_ff <= '0; sacc_ff <= '0; ph_ff <= '0; valid_ff <= 1'b0; k_ff <= '0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; ovf_ff <= ovf_in; sum_ff <= sum_in;
         cacc_ff <= cacc_in; sacc_ff <= sacc_in; ph_ff <= ph_in;
         valid_ff <= valid_in; k_ff <= k_in;
      end
      mean_ff <= mean_in; ip_ff <= ip_in; qd_ff <= qd_in; mag_ff <= mag_in;
      ang_ff <= ang_in; status_ff <= status_in; v_ff <= v_in; flip_ff <= flip_in;
      c_ff <= c_in; s_ff <= s_in; mix_phase_ff <= mix_phase_in;
      sq_n_ff <= sq_n_in; sq_r_ff <= sq_r_in; sq_b_ff <= sq_b_in; sq_v_ff <= sq_v_in;
   end

   assign busy = (state_ff != S_LOAD);
   assign rsp_valid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_mean_level = mean_ff[15:0];
   assign rsp_in_phase = ip_ff;
   assign rsp_quadrature = qd_ff;
   assign rsp_magnitude = mag_ff;
   assign rsp_phase_angle = ang_ff;
endmodule

// ===== src/liap_checker.sv =====
module liap_checker
   import liap_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [16:0] rsp_magnitude
);
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held two cycles");
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy with result shown");
   a_busy_before: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without busy");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_magnitude == '0))
      else $error("error result not cleared");
endmodule

bind lock_in_amplitude_phase_top liap_checker u_liap_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_magnitude(rsp_magnitude)
);

// ===== tb/lock_in_amplitude_phase_top_tb.sv =====
`timescale 1ns / 1ps

module lock_in_amplitude_phase_top_tb;
   import liap_pkg::*;

   localparam logic [1:0] CsrUnused = 2'd3;
   localparam int SettleCycles = 60;

   typedef struct {
      logic signed [15:0] sample;
      logic               last;
   } sample_item;

   typedef struct {
      status_type         status;
      logic signed [15:0] mean_level;
      logic signed [16:0] in_phase;
      logic signed [16:0] quadrature;
      logic [16:0]        magnitude;
      logic signed [15:0] phase_angle;
   } lockin_result;

   typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_ZERO, FILL_ALTERNATE} fill_kind;

   // turn-unit arctangent table for the reference and vectoring CORDICs
   localparam logic [31:0] ATAN_TURN [30] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_sample = '0;
   logic               req_last = 1'b0;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [15:0] rsp_mean_level;
   logic signed [16:0] rsp_in_phase;
   logic signed [16:0] rsp_quadrature;
   logic [16:0]        rsp_magnitude;
   logic signed [15:0] rsp_phase_angle;

   lock_in_amplitude_phase_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample(req_sample), .req_last(req_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_mean_level(rsp_mean_level),
      .rsp_in_phase(rsp_in_phase), .rsp_quadrature(rsp_quadrature),
      .rsp_magnitude(rsp_magnitude), .rsp_phase_angle(rsp_phase_angle)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   sample_item   pending_samples[$];
   lockin_result expected_results[$];
   int           error_count = 0;
   int           items_queued = 0;
   bit           transfer_taken = 0;
   bit           burst_mode = 0;
   int           gap_left = 0;

   // configuration shadow
   logic [31:0] cfg_phase_step = '0;
   logic [31:0] cfg_start_phase = '0;
   logic        cfg_remove_dc = 1'b0;

   // block state shadow
   logic signed [15:0] block_store [MaxSamples];
   int                 block_count = 0;
   bit                 block_overflow = 0;
   longint             block_sum = 0;

   function automatic longint round_div(longint n, longint d);
      longint a;
      longint q;
      a = (n < 0) ? -n : n;
      q = (a + d / 2) / d;
      return (n < 0) ? -q : q;
   endfunction

   function automatic longint clamp_17(longint v);
      if (v > 65535) return 65535;
      if (v < -65536) return -65536;
      return v;
   endfunction

   task automatic cordic_cos_sin(input logic [31:0] p, output longint c, output longint s);
      bit          flip;
      logic [31:0] d;
      longint      x, y, z, dx, dy;
      flip = (p[31:30] == 2'd1) || (p[31:30] == 2'd2);
      d = flip ? p - 32'h80000000 : p;
      z = longint'($signed(d));
      x = CordicGainQ30;
      y = 0;
      for (int k = 0; k < 30; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TURN[k]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TURN[k]);
         end
      end
      x = (x + 16384) >>> 15;
      y = (y + 16384) >>> 15;
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic logic [15:0] cordic_turn_angle(longint i, longint q);
      longint      x, y, dx, dy;
      logic [31:0] z;
      logic [31:0] r;
      if (i == 0 && q == 0) return '0;
      x = i * 1048576;
      y = q * 1048576;
      z = '0;
      if (x < 0) begin
         x = -x; y = -y; z = 32'h80000000;
      end
      for (int k = 0; k < 30; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (y > 0) begin
            x += dx; y -= dy; z += ATAN_TURN[k];
         end else begin
            x -= dx; y += dy; z -= ATAN_TURN[k];
         end
      end
      r = (z + 32'h8000) >> 16;
      return r[15:0];
   endfunction

   function automatic logic [63:0] root_nearest(logic [63:0] v);
      logic [63:0] r, b, n;
      r = 0;
      b = 64'd1 << 62;
      n = v;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b; r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      if (v - r * r > r) r++;
      return r;
   endfunction

   task automatic predict_sample(input logic signed [15:0] smp, input logic last);
      lockin_result res;
      longint       mean, ip, qd, v, c, s, cos_acc, sin_acc;
      logic [31:0]  ph;
      logic [63:0]  mag;
      if (block_count < MaxSamples) begin
         block_store[block_count] = smp;
         block_count++;
         block_sum += smp;
      end else begin
         block_overflow = 1;
      end
      if (!last) return;
      res = '{ST_OK, '0, '0, '0, '0, '0};
      if (block_count < 2) res.status = ST_TOO_FEW;
      else if (cfg_phase_step == 0 || cfg_phase_step[31]) res.status = ST_BAD_STEP;
      else if (block_overflow) res.status = ST_TOO_MANY;
      if (res.status == ST_OK) begin
         mean = round_div(block_sum, block_count);
         ph = cfg_start_phase;
         cos_acc = 0;
         sin_acc = 0;
         for (int k = 0; k < block_count; k++) begin
            v = longint'(block_store[k]) - (cfg_remove_dc ? mean : 0);
            cordic_cos_sin(ph, c, s);
            cos_acc += v * c;
            sin_acc -= v * s;
            ph += cfg_phase_step;
         end
         ip = clamp_17(round_div(cos_acc, longint'(block_count) * 16384));
         qd = clamp_17(round_div(sin_acc, longint'(block_count) * 16384));
         mag = root_nearest(64'(ip * ip) + 64'(qd * qd));
         res.mean_level = mean[15:0];
         res.in_phase = ip[16:0];
         res.quadrature = qd[16:0];
         res.magnitude = mag[16:0];
         res.phase_angle = cordic_turn_angle(ip, qd);
      end
      expected_results.push_back(res);
      block_count = 0;
      block_overflow = 0;
      block_sum = 0;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // transfer accepted on start && !busy
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         transfer_taken = 1;
         predict_sample(req_sample, req_last);
      end
   end

   always @(negedge clock) begin
      sample_item it;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || transfer_taken) begin
         transfer_taken = 0;
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            it = pending_samples.pop_front();
            req_sample <= it.sample;
            req_last <= it.last;
            start <= 1'b1;
            gap_left = pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      lockin_result want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_status, -1);
         end else begin
            want = expected_results.pop_front();
            if (rsp_status != want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_mean_level != want.mean_level)
               report_mismatch("mean_level", rsp_mean_level, want.mean_level);
            if (rsp_in_phase != want.in_phase)
               report_mismatch("in_phase", rsp_in_phase, want.in_phase);
            if (rsp_quadrature != want.quadrature)
               report_mismatch("quadrature", rsp_quadrature, want.quadrature);
            if (rsp_magnitude != want.magnitude)
               report_mismatch("magnitude", rsp_magnitude, want.magnitude);
            if (rsp_phase_angle != want.phase_angle)
               report_mismatch("phase_angle", rsp_phase_angle, want.phase_angle);
         end
      end
   end

   task automatic csr_write(input logic [1:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      case (index)
         CSR_PHASE_STEP:  cfg_phase_step = data;
         CSR_START_PHASE: cfg_start_phase = data;
         CSR_REMOVE_DC:   cfg_remove_dc = data[0];
         default: ;
      endcase
   endtask

   task automatic csr_done();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input logic [31:0] step, input logic [31:0] phase,
                            input logic [31:0] dc);
      csr_write(CSR_PHASE_STEP, step);
      csr_write(CSR_START_PHASE, phase);
      csr_write(CSR_REMOVE_DC, dc);
      if ($urandom_range(0, 3) == 0) csr_write(CsrUnused, $urandom);
      csr_done();
   endtask

   // everything sent and answered, plus time for the block to settle
   task automatic drain();
      while (pending_samples.size() > 0 || start || expected_results.size() > 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic queue_block(input int len, input fill_kind kind);
      sample_item it;
      for (int k = 0; k < len; k++) begin
         case (kind)
            FILL_MAX:       it.sample = 16'sh7FFF;
            FILL_MIN:       it.sample = -16'sh8000;
            FILL_ZERO:      it.sample = '0;
            FILL_ALTERNATE: it.sample = k[0] ? -16'sh8000 : 16'sh7FFF;
            default:        it.sample = 16'($urandom);
         endcase
         it.last = (k == len - 1);
         pending_samples.push_back(it);
         items_queued++;
      end
   endtask

   function automatic logic [31:0] random_step();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return 32'h80000000 | $urandom;
      if (r == 2) return 32'h7FFFFFFF;
      if (r == 3) return 32'd1;
      return $urandom_range(1, 32'h7FFFFFFF);
   endfunction

   initial begin
      int len;
      int r;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers still at reset: step zero is invalid, lone sample is too few
      queue_block(2, FILL_RANDOM);
      queue_block(1, FILL_RANDOM);
      drain();
      configure(32'd1, 32'd0, 32'd0);
      queue_block(2, FILL_MAX);
      queue_block(2, FILL_MIN);
      queue_block(3, FILL_ZERO);
      queue_block(1, FILL_MAX);
      drain();
      configure(32'h80000000, 32'hFFFFFFFF, 32'd1);
      queue_block(2, FILL_RANDOM);
      drain();
      configure(32'h7FFFFFFF, 32'hFFFFFFFF, 32'd1);
      queue_block(5, FILL_ALTERNATE);
      queue_block(2, FILL_RANDOM);
      drain();
      configure(32'h40000000, 32'h80000000, 32'd0);
      queue_block(4, FILL_MAX);
      queue_block(2, FILL_MIN);
      drain();

      // full store, then one sample beyond it
      configure($urandom_range(1, 32'h7FFFFFFF), $urandom, 32'd1);
      queue_block(MaxSamples, FILL_RANDOM);
      queue_block(MaxSamples + 1, FILL_RANDOM);
      drain();
      items_queued = 0;

      while (items_queued < 750) begin
         burst_mode = ($urandom_range(0, 4) == 0);
         configure(random_step(), $urandom, $urandom);
         repeat ($urandom_range(1, 6)) begin
            r = $urandom_range(0, 99);
            if (r < 5) len = 1;
            else if (r < 95) len = $urandom_range(2, 24);
            else len = $urandom_range(25, 150);
            r = $urandom_range(0, 19);
            queue_block(len, r == 0 ? FILL_MAX : r == 1 ? FILL_MIN :
                             r == 2 ? FILL_ALTERNATE : FILL_RANDOM);
         end
         drain();
      end

      drain();
      if (error_count == 0) begin
         $display("lock_in_amplitude_phase_top regression: pass");
      end else begin
         $display("lock_in_amplitude_phase_top regression: fail");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("lock_in_amplitude_phase_top regression: fail");
      $finish;
   end

endmodule
